// ===== rtl/coin_change_way_counter_macros.svh =====
// assertion macros shared by the coin change way counter checkers
`ifndef COIN_CHANGE_WAY_COUNTER_MACROS_SVH
`define COIN_CHANGE_WAY_COUNTER_MACROS_SVH

// property checked out of reset only
`define CCWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define CCWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/ccwc_pkg.sv =====
// shared constants and controller/datapath types of the coin change way counter
`default_nettype none
package ccwc_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VAL_W           = 10;
  localparam int WAY_W           = 63;
  localparam logic [WAY_W-1:0] WAY_MAX = {WAY_W{1'b1}};

  typedef struct packed {
    logic load_coin;
    logic issue;
    logic read_tgt;
    logic load_result;
    logic clr_step;
  } ccwc_cmd_t;

  typedef struct packed {
    logic sweep_ok;
    logic last_coin;
    logic issue_last;
    logic clr_last;
    logic out_busy;
  } ccwc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ccwc_if.sv =====
// valid/ready channel interfaces for coins, results and the target register
`default_nettype none
interface ccwc_coin_if;
  import ccwc_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] coin_value;
  logic             last_coin;
  modport source (output valid, output coin_value, output last_coin, input ready);
  modport sink (input valid, input coin_value, input last_coin, output ready);
endinterface

interface ccwc_result_if;
  import ccwc_pkg::*;
  logic             valid;
  logic             ready;
  logic [WAY_W-1:0] way_count;
  logic             count_overflow;
  modport source (output valid, output way_count, output count_overflow, input ready);
  modport sink (input valid, input way_count, input count_overflow, output ready);
endinterface

interface ccwc_cfg_if;
  import ccwc_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] target_amount;
  modport source (output valid, output target_amount, input ready);
  modport sink (input valid, input target_amount, output ready);
endinterface
`default_nettype wire

// ===== rtl/ccwc_ctrl.sv =====
// controller state machine: sequences sweep, result read and table clear
`default_nettype none
module ccwc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ccwc_pkg::ccwc_stat_t  stat_i,
  output ccwc_pkg::ccwc_cmd_t        cmd_o
);
  import ccwc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.load_coin = 1'b1;
          state_d         = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (stat_i.sweep_ok)       state_d = ST_SWEEP;
        else if (stat_i.last_coin) state_d = ST_READ;
        else                       state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.issue = 1'b1;
        if (stat_i.issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = stat_i.last_coin ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        cmd_o.read_tgt = 1'b1;
        state_d        = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule
`default_nettype wire

// ===== rtl/ccwc_datapath.sv =====
// datapath: way table memory, two-stage sweep pipeline, output register
`default_nettype none
module ccwc_datapath #(
  parameter int TABLE_DEPTH = ccwc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ccwc_pkg::VAL_W-1:0]   cfg_data_i,
  input  wire logic [ccwc_pkg::VAL_W-1:0]   coin_i,
  input  wire logic                         last_i,
  input  wire ccwc_pkg::ccwc_cmd_t          cmd_i,
  output ccwc_pkg::ccwc_stat_t              stat_o,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [ccwc_pkg::WAY_W-1:0]        way_count_o,
  output logic                              count_overflow_o
);
  import ccwc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [WAY_W-1:0] mem_q [TABLE_DEPTH];

  logic [VAL_W-1:0] target_q;
  logic [VAL_W-1:0] coin_q;
  logic             last_q;
  logic [AW-1:0]    tgt_q;
  logic [AW-1:0]    j_q;
  logic [AW-1:0]    jp_q;
  logic             p_q;
  logic [WAY_W-1:0] rda_q, rdb_q, lastv_q;
  logic             ovf_q;
  logic [AW-1:0]    cnt_q;
  logic             out_valid_q;
  logic [WAY_W-1:0] out_way_q;
  logic             out_ovf_q;

  logic [AW-1:0]    tgt_eff;
  logic [AW-1:0]    coin_a;
  logic [AW-1:0]    addr_b;
  logic [WAY_W-1:0] addend;
  logic [WAY_W:0]   sum;
  logic             sat;
  logic [WAY_W-1:0] new_v;

  // clamp the target to the last table entry
  assign tgt_eff = (32'(target_q) > TABLE_DEPTH - 1) ? AW'(TABLE_DEPTH - 1) : AW'(target_q);
  // coin fits the index width whenever a sweep runs
  assign coin_a  = AW'(coin_q);
  assign addr_b  = j_q - coin_a;

  // entry at the coin gains one, later entries gain the entry one coin lower
  always_comb begin
    if (jp_q == coin_a)            addend = WAY_W'(1);
    else if (coin_q == VAL_W'(1))  addend = lastv_q;  // lower entry written last cycle
    else                           addend = rdb_q;
    sum   = {1'b0, rda_q} + {1'b0, addend};
    sat   = sum[WAY_W];
    new_v = sat ? WAY_MAX : sum[WAY_W-1:0];
  end

  always_comb begin
    stat_o.sweep_ok   = (coin_q != '0) && (32'(coin_q) <= 32'(tgt_q));
    stat_o.last_coin  = last_q;
    stat_o.issue_last = (j_q == tgt_q);
    stat_o.clr_last   = (cnt_q == AW'(TABLE_DEPTH - 1));
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) mem_q[cnt_q] <= '0;
    else if (p_q)       mem_q[jp_q]  <= new_v;
    if (cmd_i.issue) begin
      rda_q <= mem_q[j_q];
      rdb_q <= mem_q[addr_b];
    end else if (cmd_i.read_tgt) begin
      rda_q <= mem_q[tgt_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coin) begin
      coin_q <= coin_i;
      last_q <= last_i;
      tgt_q  <= tgt_eff;
      j_q    <= AW'(coin_i);
    end else if (cmd_i.issue) begin
      j_q <= j_q + AW'(1);
    end
    if (cmd_i.issue) jp_q <= j_q;
    if (p_q)         lastv_q <= new_v;
    if (cmd_i.load_result) begin
      out_way_q <= rda_q;
      out_ovf_q <= ovf_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      p_q         <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) target_q <= cfg_data_i;
      p_q <= cmd_i.issue;
      if (cmd_i.load_result)  ovf_q <= 1'b0;
      else if (p_q && sat)    ovf_q <= 1'b1;
      if (cmd_i.load_result)  cnt_q <= '0;
      else if (cmd_i.clr_step) cnt_q <= cnt_q + AW'(1);
      if (cmd_i.load_result)  out_valid_q <= 1'b1;
      else if (out_ready_i)   out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign way_count_o      = out_way_q;
  assign count_overflow_o = out_ovf_q;

endmodule
`default_nettype wire

// ===== rtl/coin_change_way_counter.sv =====
// top level of the coin change way counter
//
//   channel    dir  payload                          transfer when
//   coin_ch    in   coin_value[9:0], last_coin       valid && ready
//   result_ch  out  way_count[62:0], count_overflow  valid && ready
//   cfg_ch     in   target_amount[9:0]               valid && ready (ready tied high)
//
// each coin passes idle and setup; when 1 <= coin <= target a sweep over entries coin to target and a drain follow
// a last coin adds a read of the target entry, then a clearing pass over the table
// (one entry per cycle through the single write port)
// after reset the same clearing pass runs before coin_ch is ready
// the result waits in an output register; while it is full the next result
// waits in the table read register, and coin_ch stays not ready until it moves in
`default_nettype none
module coin_change_way_counter #(
  parameter int TABLE_DEPTH = ccwc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ccwc_coin_if.sink       coin_ch,
  ccwc_result_if.source   result_ch,
  ccwc_cfg_if.sink        cfg_ch
);
  import ccwc_pkg::*;

  ccwc_cmd_t  cmd;
  ccwc_stat_t stat;
  logic       in_ready;

  // the target register takes a write in any cycle
  assign cfg_ch.ready = 1'b1;
  assign coin_ch.ready = in_ready;

  // state machine: clear, idle, setup, sweep, drain, read, result
  ccwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (coin_ch.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table memory and saturating adder; one entry per cycle during a sweep
  ccwc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_ch.valid),
    .cfg_data_i       (cfg_ch.target_amount),
    .coin_i           (coin_ch.coin_value),
    .last_i           (coin_ch.last_coin),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (result_ch.ready),
    .out_valid_o      (result_ch.valid),
    .way_count_o      (result_ch.way_count),
    .count_overflow_o (result_ch.count_overflow)
  );

endmodule
`default_nettype wire

// ===== rtl/ccwc_checker.sv =====
// port-level assertions for the coin change way counter, bound to the top level
`default_nettype none
`include "coin_change_way_counter_macros.svh"
module ccwc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [ccwc_pkg::WAY_W-1:0] way_count_i
);
  import ccwc_pkg::*;

  // block is quiet once reset has been seen, and right after it
  `CCWC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!in_ready_i && !out_valid_i), "busy in reset")

  // one coin at a time: ready drops after each coin transfer
  `CCWC_ASSERT(a_one_coin, (in_valid_i && in_ready_i) |=> !in_ready_i, "ready held after coin")

  // a new result is produced while no coin can be taken
  `CCWC_ASSERT(a_result_busy, $rose(out_valid_i) |-> !in_ready_i, "result while ready")

  // stalled result holds its count
  `CCWC_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(way_count_i)), "result dropped")

endmodule

bind coin_change_way_counter ccwc_checker u_ccwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (coin_ch.valid),
  .in_ready_i  (coin_ch.ready),
  .out_valid_i (result_ch.valid),
  .out_ready_i (result_ch.ready),
  .way_count_i (result_ch.way_count)
);
`default_nettype wire

// ===== bench/coin_change_way_counter_tb.sv =====
// self-checking bench for the coin change way counter: directed and random coin sets
module coin_change_way_counter_tb;
  import ccwc_pkg::*;

  localparam int SETTLE_CYCLES = 2200;  // longest sweep plus read plus table clear
  localparam int RANDOM_PHASES = 16;
  localparam int RANDOM_ITEMS  = 555;
  localparam int HOLD_CYCLES   = 8000;
  localparam int MAX_TARGET    = TABLE_DEPTH_DEF - 1;

  // tracks the way table and the overflow flag, holds the counts still owed
  class coin_ways_predictor;
    typedef struct {
      bit [WAY_W-1:0] way_count;
      bit             count_overflow;
    } way_result_t;

    bit [WAY_W-1:0] ways [TABLE_DEPTH_DEF];
    bit             overflow_seen;
    int             target;
    way_result_t    expected_counts[$];
    int             mismatches;

    function new();
      foreach (ways[i]) ways[i] = '0;
      overflow_seen = 1'b0;
      target        = 0;
      mismatches    = 0;
    endfunction

    function void set_target(int value);
      target = value;
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction

    // saturating add, a clamp marks the problem as overflowed
    function bit [WAY_W-1:0] clamp_add(bit [WAY_W-1:0] a, bit [WAY_W-1:0] b);
      bit [WAY_W:0] total;
      total = a + b;
      if (total > WAY_MAX) begin
        overflow_seen = 1'b1;
        return WAY_MAX;
      end
      return total[WAY_W-1:0];
    endfunction

    // one accepted coin: sweep the table, and on the last coin owe a count
    function void note_coin(int coin, bit last);
      int             tgt;
      bit [WAY_W-1:0] v;
      way_result_t    owed;
      tgt = (target > MAX_TARGET) ? MAX_TARGET : target;
      if (coin != 0 && coin <= tgt) begin
        for (int j = 1; j <= tgt; j++) begin
          v = ways[j];
          if (j == coin) v = clamp_add(v, WAY_W'(1));
          if (j >= coin) v = clamp_add(v, ways[j-coin]);
          ways[j] = v;
        end
      end
      if (last) begin
        owed.way_count      = ways[tgt];
        owed.count_overflow = overflow_seen;
        expected_counts.push_back(owed);
        foreach (ways[i]) ways[i] = '0;
        overflow_seen = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [WAY_W-1:0] count, logic ovf);
      way_result_t owed;
      if (expected_counts.size() == 0) begin
        report($sformatf("count %0d arrived with nothing owed", count));
        return;
      end
      owed = expected_counts.pop_front();
      if (count !== owed.way_count)
        report($sformatf("way_count %0d, predicted %0d", count, owed.way_count));
      if (ovf !== owed.count_overflow)
        report($sformatf("count_overflow %b, predicted %b", ovf, owed.count_overflow));
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // shared idling controls: calm turns idling off, hold_req asks for one long stall
  bit calm;
  bit hold_req;
  bit hold_done;

  coin_ways_predictor predictor = new();

  ccwc_coin_if   coin_ch ();
  ccwc_result_if result_ch ();
  ccwc_cfg_if    cfg_ch ();

  coin_change_way_counter uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coin_ch   (coin_ch),
    .result_ch (result_ch),
    .cfg_ch    (cfg_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // idle with a chance of roughly 37 in a hundred unless the phase is calm
  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // coin picker: mostly coins that sweep, some above the target, a few zero, the rest anywhere
  function automatic logic [VAL_W-1:0] pick_coin(int tgt);
    int r;
    r = $urandom_range(99);
    if (r < 72 && tgt > 0) begin
      if ($urandom_range(1)) return VAL_W'($urandom_range(1, (tgt < 16) ? tgt : 16));
      return VAL_W'($urandom_range(1, tgt));
    end
    if (r < 86 && tgt < MAX_TARGET) return VAL_W'($urandom_range(tgt + 1, MAX_TARGET));
    if (r < 91) return '0;
    return VAL_W'($urandom_range(1, MAX_TARGET));
  endfunction

  // one target per random phase: zero, the top, and small, medium and large ones
  function automatic int phase_target(int p);
    case (p)
      0:       return 0;
      1, 9:    return MAX_TARGET;
      6:       return $urandom_range(201, MAX_TARGET - 1);
      default: begin
        if (p % 2) return $urandom_range(1, 40);
        return $urandom_range(41, 200);
      end
    endcase
  endfunction

  // result side: random stalls, and once a long hold-off so the block backs up
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        result_ch.ready <= !idle_roll();
      end
    end
  end

  // every result transfer is checked against the oldest owed count
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready)
      predictor.check_result(result_ch.way_count, result_ch.count_overflow);
  end

  // offer one coin, with random gaps in front, until the block takes it;
  // valid stays high afterwards so back-to-back transfers are possible
  task automatic send_coin(logic [VAL_W-1:0] coin, bit last);
    while (idle_roll()) begin
      coin_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    coin_ch.valid      <= 1'b1;
    coin_ch.coin_value <= coin;
    coin_ch.last_coin  <= last;
    @(posedge clk_i);
    while (!coin_ch.ready) @(posedge clk_i);
    predictor.note_coin(int'(coin), last);
  endtask

  // sender stops and waits for every owed count, then lets the block go quiet
  task automatic settle();
    coin_ch.valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write only once the block is idle
  task automatic write_target(int value);
    settle();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.target_amount <= VAL_W'(value);
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    predictor.set_target(value);
  endtask

  initial begin : stimulus
    int               tgt;
    int               quota;
    int               sent;
    int               phase_sent;
    int               n;
    bit               last;
    logic [VAL_W-1:0] coin;

    coin_ch.valid        <= 1'b0;
    coin_ch.coin_value   <= '0;
    coin_ch.last_coin    <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.target_amount <= '0;
    calm                 <= 1'b0;
    hold_req             <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // target zero: entry zero never changes, so the count is zero
    write_target(0);
    send_coin(VAL_W'(MAX_TARGET), 1'b1);

    // zero coin still closes the problem; coin above target leaves table alone
    write_target(5);
    send_coin(VAL_W'(0), 1'b1);
    send_coin(VAL_W'(7), 1'b0);
    send_coin(VAL_W'(5), 1'b1);
    send_coin(VAL_W'(1), 1'b0);
    send_coin(VAL_W'(2), 1'b1);

    // coin equal to the top target
    write_target(MAX_TARGET);
    send_coin(VAL_W'(MAX_TARGET), 1'b1);

    // target moved while a problem is open: later sweeps use the new value
    write_target(10);
    send_coin(VAL_W'(2), 1'b0);
    send_coin(VAL_W'(3), 1'b0);
    write_target(5);
    send_coin(VAL_W'(1), 1'b1);

    // sixteen small coins against the top target run past 2^63-1
    write_target(MAX_TARGET);
    for (int c = 1; c <= 16; c++) send_coin(VAL_W'(c), c == 16);

    // random phases, each with its own target; problems are whole coin sets
    // with noise coins mixed in, some left open across a target change
    sent = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tgt = phase_target(p);
      write_target(tgt);
      calm <= (p == 5);
      if (p == 3) hold_req <= 1'b1;
      quota      = (RANDOM_ITEMS - sent) / (RANDOM_PHASES - p);
      phase_sent = 0;
      while (phase_sent < quota) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          coin = pick_coin(tgt);
          last = (k == n - 1);
          send_coin(coin, last);
          phase_sent++;
        end
      end
      if ((p % 2) && $urandom_range(1)) begin
        n = $urandom_range(1, 2);
        for (int k = 0; k < n; k++) send_coin(pick_coin(tgt), 1'b0);
      end
      sent += phase_sent;
    end
    calm <= 1'b0;

    settle();
    if (predictor.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin : watchdog
    #50000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
